// ----- rtl/lif_pkg.sv -----
package lif_pkg;

  // Neurons that can send to this one; one weight each.
  localparam int NEURONS = 64;
  localparam int ADDR_W  = $clog2(NEURONS);
  localparam int IDX_W   = 6;
  localparam int CFG_W   = 16;
  localparam int Q_W     = 16;

  typedef logic [1:0]            func_t;
  typedef logic [2:0]            cfg_idx_t;
  typedef logic signed [Q_W-1:0] q88_t;

  localparam func_t FUNC_TICK  = 2'd0;
  localparam func_t FUNC_SPIKE = 2'd1;
  localparam func_t FUNC_STIM  = 2'd2;
  localparam func_t FUNC_WRITE = 2'd3;

  localparam cfg_idx_t REG_REFRACTORY = 3'd0;
  localparam cfg_idx_t REG_RESISTANCE = 3'd1;
  localparam cfg_idx_t REG_TAU_RECIP  = 3'd2;
  localparam cfg_idx_t REG_THRESHOLD  = 3'd3;
  localparam cfg_idx_t REG_SPIKE_STEP = 3'd4;
  localparam cfg_idx_t REG_INPUT_MODE = 3'd5;
  localparam cfg_idx_t REG_RUN_LENGTH = 3'd6;

  // Clamp a 28-bit signed value to signed 16 bits.
  function automatic q88_t sat16(input logic signed [27:0] v);
    q88_t r;
    if (v > 28'sd32767) begin
      r = 16'sh7fff;
    end else if (v < -28'sd32768) begin
      r = 16'sh8000;
    end else begin
      r = v[15:0];
    end
    return r;
  endfunction

  function automatic logic [15:0] inc_sat16(input logic [15:0] v);
    logic [15:0] r;
    r = (v == 16'hffff) ? v : v + 16'd1;
    return r;
  endfunction

endpackage

// ----- rtl/lif_ram.sv -----
module lif_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ----- rtl/leaky_integrate_fire_neuron_top.sv -----
// Leaky integrate-and-fire neuron, Q8.8 fixed point. One beat in, one beat out, for every
// item: tick, incoming spike, stimulus or weight write. Items are taken one at a time;
// in_stall is high from acceptance until the result has been registered for the output.
// Past the run end, and for a weight write, an out-of-range spike, or a tick in the
// refractory window or in input mode, the item goes straight to the output register. Else
// a spike reads its weight (registered RAM read) and adds it, a stimulus fires, and a
// leaking tick uses one shared 26 x 17 bit multiplier twice (current x resistance, then
// difference x tau reciprocal), followed by the saturating add and the threshold compare.
// While out_stall holds a result, the next item waits in ST_DONE. The weight store is a
// 64-entry RAM; per-entry valid flops, cleared by reset, make unwritten weights read as
// zero, so no clearing pass is needed. Configuration writes (cfg_we, cfg_index, cfg_wdata)
// take effect at once and are only to be made while the block is idle.
module leaky_integrate_fire_neuron_top (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        cfg_we,
  input  lif_pkg::cfg_idx_t           cfg_index,
  input  logic [lif_pkg::CFG_W-1:0]   cfg_wdata,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  lif_pkg::func_t              in_func,
  input  logic [lif_pkg::IDX_W-1:0]   in_sender_index,
  input  lif_pkg::q88_t               in_weight_value,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic                        out_fired,
  output lif_pkg::q88_t               out_potential,
  output logic [15:0]                 out_fire_total,
  output logic [15:0]                 out_spikes_received
);
  import lif_pkg::*;

  // sequencer codes
  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_SPK  = 3'd1; // weight read back, add to current
  localparam logic [2:0] ST_MUL1 = 3'd2; // drive = I * R
  localparam logic [2:0] ST_MUL2 = 3'd3; // (drive - Vlast) * tau_recip
  localparam logic [2:0] ST_LEAK = 3'd4; // V = sat(Vlast + prod >>> 16)
  localparam logic [2:0] ST_CHK  = 3'd5; // threshold compare
  localparam logic [2:0] ST_FIRE = 3'd6; // V += step, count, stamp time
  localparam logic [2:0] ST_DONE = 3'd7; // load output register

  // configuration
  logic [7:0]  refr_r, res_r;
  logic [15:0] tau_r, run_r;
  q88_t        thr_r, step_r;
  logic        mode_r;

  // neuron state
  logic [2:0]  state_r, state_nxt;
  func_t       func_r, func_nxt;
  logic [ADDR_W-1:0] idx_r, idx_nxt;
  logic [15:0] tick_r, tick_nxt;
  logic [15:0] last_r, last_nxt;
  q88_t        pot_r, pot_nxt;
  q88_t        prev_r, prev_nxt;
  q88_t        sum_r, sum_nxt;
  logic [15:0] fcnt_r, fcnt_nxt;
  logic [15:0] rcnt_r, rcnt_nxt;
  logic        fired_r, fired_nxt;
  logic signed [42:0] prod_r, prod_nxt;
  logic [NEURONS-1:0] wvalid_r, wvalid_nxt;

  // output register
  logic        out_valid_r, out_valid_nxt;
  logic        out_fired_r, out_fired_nxt;
  q88_t        out_pot_r, out_pot_nxt;
  logic [15:0] out_fcnt_r, out_fcnt_nxt;
  logic [15:0] out_rcnt_r, out_rcnt_nxt;

  // datapath
  logic               accept;
  logic [15:0]        tick_inc, since;
  logic               in_range;
  logic signed [25:0] mul_a;
  logic signed [16:0] mul_b;
  logic signed [42:0] mul_p;
  logic signed [26:0] leak_q;
  q88_t               leak_v, spk_sum, fire_v, wsel;
  logic [15:0]        ram_rdata;
  logic               ram_we;

  assign in_stall = (state_r != ST_IDLE);
  assign accept   = in_valid && !in_stall;
  assign tick_inc = inc_sat16(tick_r);
  assign since    = tick_inc - last_r;
  assign in_range = 32'(in_sender_index) < 32'(NEURONS);

  // shared multiplier: first pass I*R, second pass (drive - Vlast)*tau
  always_comb begin
    if (state_r == ST_MUL1) begin
      mul_a = {{10{sum_r[15]}}, sum_r};
      mul_b = {9'd0, res_r};
    end else begin
      mul_a = prod_r[25:0] - {{10{prev_r[15]}}, prev_r};
      mul_b = {1'b0, tau_r};
    end
    mul_p = mul_a * mul_b;
  end

  // arithmetic shift of the product floors the quotient by 65536
  assign leak_q  = prod_r[42:16];
  assign leak_v  = sat16({leak_q[26], leak_q} + {{12{prev_r[15]}}, prev_r});
  assign wsel    = wvalid_r[idx_r] ? q88_t'(ram_rdata) : '0;
  assign spk_sum = sat16({{12{sum_r[15]}}, sum_r} + {{12{wsel[15]}}, wsel});
  assign fire_v  = sat16({{12{pot_r[15]}}, pot_r} + {{12{step_r[15]}}, step_r});

  assign ram_we = accept && (in_func == FUNC_WRITE) && (tick_r < run_r) && in_range;

  lif_ram #(
    .WIDTH (Q_W),
    .DEPTH (NEURONS)
  ) u_wram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (in_sender_index[ADDR_W-1:0]),
    .wdata (in_weight_value),
    .re    (accept),
    .raddr (in_sender_index[ADDR_W-1:0]),
    .rdata (ram_rdata)
  );

  always_comb begin
    state_nxt     = state_r;
    func_nxt      = func_r;
    idx_nxt       = idx_r;
    tick_nxt      = tick_r;
    last_nxt      = last_r;
    pot_nxt       = pot_r;
    prev_nxt      = prev_r;
    sum_nxt       = sum_r;
    fcnt_nxt      = fcnt_r;
    rcnt_nxt      = rcnt_r;
    fired_nxt     = fired_r;
    prod_nxt      = prod_r;
    wvalid_nxt    = wvalid_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_fired_nxt = out_fired_r;
    out_pot_nxt   = out_pot_r;
    out_fcnt_nxt  = out_fcnt_r;
    out_rcnt_nxt  = out_rcnt_r;

    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          func_nxt  = in_func;
          idx_nxt   = in_sender_index[ADDR_W-1:0];
          fired_nxt = 1'b0;
          state_nxt = ST_DONE;
          if (in_func == FUNC_TICK) begin
            if (tick_inc < run_r) begin
              tick_nxt = tick_inc;
              if (!mode_r) begin
                if (since > {8'd0, refr_r}) begin
                  state_nxt = ST_MUL1;
                end else begin
                  // refractory: hold at zero
                  pot_nxt  = '0;
                  prev_nxt = '0;
                  sum_nxt  = '0;
                end
              end
            end
          end else if (tick_r < run_r) begin
            unique case (in_func)
              FUNC_SPIKE: begin
                rcnt_nxt = inc_sat16(rcnt_r);
                if (in_range) begin
                  state_nxt = ST_SPK;
                end
              end
              FUNC_STIM: state_nxt = ST_FIRE;
              FUNC_WRITE: begin
                if (in_range) begin
                  wvalid_nxt[in_sender_index[ADDR_W-1:0]] = 1'b1;
                end
              end
              default: state_nxt = ST_DONE;
            endcase
          end
        end
      end
      ST_SPK: begin
        sum_nxt   = spk_sum;
        state_nxt = ST_DONE;
      end
      ST_MUL1: begin
        prod_nxt  = mul_p;
        state_nxt = ST_MUL2;
      end
      ST_MUL2: begin
        prod_nxt  = mul_p;
        state_nxt = ST_LEAK;
      end
      ST_LEAK: begin
        pot_nxt   = leak_v;
        prev_nxt  = leak_v;
        sum_nxt   = '0;
        state_nxt = ST_CHK;
      end
      ST_CHK: begin
        state_nxt = (pot_r >= thr_r) ? ST_FIRE : ST_DONE;
      end
      ST_FIRE: begin
        pot_nxt   = fire_v;
        fcnt_nxt  = inc_sat16(fcnt_r);
        last_nxt  = tick_r;
        fired_nxt = 1'b1;
        // after a tick the leak base follows the fired potential; a stimulus leaves it
        if (func_r == FUNC_TICK) begin
          prev_nxt = fire_v;
        end
        state_nxt = ST_DONE;
      end
      ST_DONE: begin
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt = 1'b1;
          out_fired_nxt = fired_r;
          out_pot_nxt   = pot_r;
          out_fcnt_nxt  = fcnt_r;
          out_rcnt_nxt  = rcnt_r;
          state_nxt     = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      refr_r      <= 8'd30;
      res_r       <= 8'd10;
      tau_r       <= 16'd262;
      thr_r       <= 16'sd410;
      step_r      <= 16'sd64;
      mode_r      <= 1'b0;
      run_r       <= 16'hffff;
      state_r     <= ST_IDLE;
      tick_r      <= '0;
      last_r      <= '0;
      pot_r       <= '0;
      prev_r      <= '0;
      sum_r       <= '0;
      fcnt_r      <= '0;
      rcnt_r      <= '0;
      wvalid_r    <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          REG_REFRACTORY: refr_r <= cfg_wdata[7:0];
          REG_RESISTANCE: res_r  <= cfg_wdata[7:0];
          REG_TAU_RECIP:  tau_r  <= cfg_wdata;
          REG_THRESHOLD:  thr_r  <= cfg_wdata;
          REG_SPIKE_STEP: step_r <= cfg_wdata;
          REG_INPUT_MODE: mode_r <= cfg_wdata[0];
          REG_RUN_LENGTH: run_r  <= cfg_wdata;
          default: ;
        endcase
      end
      state_r     <= state_nxt;
      tick_r      <= tick_nxt;
      last_r      <= last_nxt;
      pot_r       <= pot_nxt;
      prev_r      <= prev_nxt;
      sum_r       <= sum_nxt;
      fcnt_r      <= fcnt_nxt;
      rcnt_r      <= rcnt_nxt;
      wvalid_r    <= wvalid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload, no reset
  always_ff @(posedge clk) begin
    func_r      <= func_nxt;
    idx_r       <= idx_nxt;
    fired_r     <= fired_nxt;
    prod_r      <= prod_nxt;
    out_fired_r <= out_fired_nxt;
    out_pot_r   <= out_pot_nxt;
    out_fcnt_r  <= out_fcnt_nxt;
    out_rcnt_r  <= out_rcnt_nxt;
  end

  assign out_valid           = out_valid_r;
  assign out_fired           = out_fired_r;
  assign out_potential       = out_pot_r;
  assign out_fire_total      = out_fcnt_r;
  assign out_spikes_received = out_rcnt_r;

endmodule

// ----- test/leaky_integrate_fire_neuron_check.sv -----
`timescale 1ns / 1ps
module leaky_integrate_fire_neuron_check (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       cfg_we,
  input  lif_pkg::cfg_idx_t          cfg_index,
  input  logic [lif_pkg::CFG_W-1:0]  cfg_wdata,
  input  logic                       in_valid,
  input  logic                       in_stall,
  input  lif_pkg::func_t             in_func,
  input  logic [lif_pkg::IDX_W-1:0]  in_sender_index,
  input  lif_pkg::q88_t              in_weight_value,
  input  logic                       out_valid,
  input  logic                       out_stall,
  input  logic                       out_fired,
  input  lif_pkg::q88_t              out_potential,
  input  logic [15:0]                out_fire_total,
  input  logic [15:0]                out_spikes_received,
  output int                         outstanding,
  output int                         mismatches
);
  import lif_pkg::*;

  typedef struct packed {
    logic        fired;
    q88_t        potential;
    logic [15:0] fire_total;
    logic [15:0] spikes_received;
  } neuron_out_t;

  // shadow registers
  logic [7:0]  refr_ticks;
  logic [7:0]  resistance;
  logic [15:0] tau_recip;
  q88_t        threshold;
  q88_t        step;
  logic        stim_only;
  logic [15:0] run_len;

  // shadow neuron state
  logic [15:0] tick_now;
  logic [15:0] last_fire;
  logic [15:0] fire_cnt;
  logic [15:0] spike_cnt;
  q88_t        vmem;
  q88_t        vprev;
  q88_t        isum;
  q88_t        weight [NEURONS];

  neuron_out_t due_q [$];
  neuron_out_t want;

  function automatic q88_t clamp16(longint v);
    if (v > 32767) return 16'sh7fff;
    if (v < -32768) return 16'sh8000;
    return v[15:0];
  endfunction

  function automatic logic [15:0] count_up(logic [15:0] v);
    return (v == 16'hffff) ? v : v + 16'd1;
  endfunction

  function automatic void fire_now(logic [15:0] at);
    vmem      = clamp16(longint'(vmem) + longint'(step));
    fire_cnt  = count_up(fire_cnt);
    last_fire = at;
  endfunction

  function automatic neuron_out_t advance(func_t f, logic [IDX_W-1:0] src, q88_t w);
    neuron_out_t r;
    logic [15:0] t;
    logic [15:0] since;
    longint      drive;
    longint      leak;
    logic        fired;
    fired = 1'b0;
    if (f == FUNC_TICK) begin
      t = count_up(tick_now);
      if (t < run_len) begin
        tick_now = t;
        if (!stim_only) begin
          since = t - last_fire;
          if (since > 16'(refr_ticks)) begin
            drive = longint'(isum) * longint'(resistance);
            // arithmetic shift gives the floor of the Q0.16 product
            leak  = ((drive - longint'(vprev)) * longint'(tau_recip)) >>> 16;
            vmem  = clamp16(longint'(vprev) + leak);
            if (vmem >= threshold) begin
              fire_now(t);
              fired = 1'b1;
            end
          end else begin
            vmem = '0;
          end
          isum  = '0;
          vprev = vmem;
        end
      end
    end else if (tick_now < run_len) begin
      case (f)
        FUNC_SPIKE: begin
          spike_cnt = count_up(spike_cnt);
          if (int'(src) < NEURONS) isum = clamp16(longint'(isum) + longint'(weight[src]));
        end
        FUNC_STIM: begin
          fire_now(tick_now);
          fired = 1'b1;
        end
        FUNC_WRITE: begin
          if (int'(src) < NEURONS) weight[src] = w;
        end
        default: ;
      endcase
    end
    r.fired           = fired;
    r.potential       = vmem;
    r.fire_total      = fire_cnt;
    r.spikes_received = spike_cnt;
    return r;
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      refr_ticks = 8'd30;
      resistance = 8'd10;
      tau_recip  = 16'd262;
      threshold  = 16'sd410;
      step       = 16'sd64;
      stim_only  = 1'b0;
      run_len    = 16'hffff;
      tick_now   = '0;
      last_fire  = '0;
      fire_cnt   = '0;
      spike_cnt  = '0;
      vmem       = '0;
      vprev      = '0;
      isum       = '0;
      for (int i = 0; i < NEURONS; i++) weight[ADDR_W'(i)] = '0;
      due_q.delete();
      mismatches = 0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_REFRACTORY: refr_ticks = cfg_wdata[7:0];
          REG_RESISTANCE: resistance = cfg_wdata[7:0];
          REG_TAU_RECIP:  tau_recip  = cfg_wdata[15:0];
          REG_THRESHOLD:  threshold  = cfg_wdata[15:0];
          REG_SPIKE_STEP: step       = cfg_wdata[15:0];
          REG_INPUT_MODE: stim_only  = cfg_wdata[0];
          REG_RUN_LENGTH: run_len    = cfg_wdata[15:0];
          default: ;
        endcase
      end
      if (in_valid && !in_stall)
        due_q.push_back(advance(in_func, in_sender_index, in_weight_value));
      if (out_valid && !out_stall) begin
        if (due_q.size() == 0) begin
          mismatches++;
          $error("result beat with nothing expected");
        end else begin
          want = due_q.pop_front();
          if (out_fired !== want.fired) begin
            mismatches++;
            $error("fired: expected %0d, got %0d", want.fired, out_fired);
          end
          if (out_potential !== want.potential) begin
            mismatches++;
            $error("potential: expected %0d, got %0d", want.potential, out_potential);
          end
          if (out_fire_total !== want.fire_total) begin
            mismatches++;
            $error("fire_total: expected %0d, got %0d", want.fire_total, out_fire_total);
          end
          if (out_spikes_received !== want.spikes_received) begin
            mismatches++;
            $error("spikes_received: expected %0d, got %0d", want.spikes_received,
                   out_spikes_received);
          end
        end
      end
    end
    outstanding = due_q.size();
  end

endmodule

// ----- test/leaky_integrate_fire_neuron_top_test.sv -----
`timescale 1ns / 1ps
module leaky_integrate_fire_neuron_top_test;
  import lif_pkg::*;

  localparam int ITEM_GOAL      = 1650;  // beats that the neuron actually acts on
  localparam int PHASE_ITEMS    = 130;
  localparam int SHORT_PHASE    = 60;    // end-of-run phases, mostly ignored beats
  localparam int HOT_SENDERS    = 8;     // senders whose weights get loaded each phase
  localparam int REG_COUNT      = 7;
  localparam int LONG_HOLD      = 400;   // receiver hold-off, in cycles
  localparam int SETTLE_CYCLES  = 20;    // settling margin after the final drain
  localparam int WATCHDOG_LIMIT = 4000;

  logic              clk             = 1'b0;
  logic              rst_n           = 1'b0;
  logic              cfg_we          = 1'b0;
  cfg_idx_t          cfg_index       = REG_REFRACTORY;
  logic [CFG_W-1:0]  cfg_wdata       = '0;
  logic              in_valid        = 1'b0;
  logic              in_stall;
  func_t             in_func         = FUNC_TICK;
  logic [IDX_W-1:0]  in_sender_index = '0;
  q88_t              in_weight_value = '0;
  logic              out_valid;
  logic              out_stall       = 1'b0;
  logic              out_fired;
  q88_t              out_potential;
  logic [15:0]       out_fire_total;
  logic [15:0]       out_spikes_received;

  int outstanding;
  int mismatches;

  leaky_integrate_fire_neuron_top dut (.*);

  leaky_integrate_fire_neuron_check compare_u (.*);

  // 2 ns period
  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Stimulus-side bookkeeping. tick_now mirrors the neuron's time only so that
  // beats ignored past the end of the run are left out of the item count, and
  // so that one phase can put the run end a few ticks ahead.
  int          tick_now    = 0;
  int          run_len_now = 65535;
  int          items_sent  = 0;
  int          phases_run  = 0;
  bit          gaps_on     = 1'b1;
  logic [15:0] regs_next [REG_COUNT];

  // Long hold requests: the stimulus bumps holds_asked, the stall process serves them.
  int holds_asked = 0;
  int holds_done;
  int stall_left;
  int stall_roll;
  int quiet_cycles = 0;

  // Receiver: runs of stall and no stall, mostly short, some long, plus long
  // free stretches. A requested hold raises out_stall and keeps it up while
  // stall_left counts down from LONG_HOLD, so the block fills and pushes back on the sender.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall  <= 1'b0;
      stall_left <= 0;
      holds_done <= 0;
    end else if (holds_done != holds_asked) begin
      out_stall  <= 1'b1;
      stall_left <= LONG_HOLD;
      holds_done <= holds_done + 1;
    end else if (stall_left > 0) begin
      stall_left <= stall_left - 1;
    end else begin
      stall_roll = $urandom_range(0, 99);
      if (stall_roll < 50) begin
        out_stall  <= 1'b0;
        stall_left <= $urandom_range(0, 6);
      end else if (stall_roll < 60) begin
        out_stall  <= 1'b0;
        stall_left <= $urandom_range(20, 80);
      end else if (stall_roll < 93) begin
        out_stall  <= 1'b1;
        stall_left <= $urandom_range(0, 3);
      end else begin
        out_stall  <= 1'b1;
        stall_left <= $urandom_range(10, 40);
      end
    end
  end

  // Watchdog: too long without a beat on either channel means a hang.
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("end of test: mismatches");
      $finish;
    end
  end

  // Sender gap before a beat: mostly none, now and then a long one.
  function automatic int pick_gap();
    int roll;
    roll = $urandom_range(0, 99);
    if (!gaps_on || roll < 55) return 0;
    if (roll < 85) return $urandom_range(1, 3);
    if (roll < 96) return $urandom_range(4, 10);
    return $urandom_range(15, 40);
  endfunction

  // Most traffic comes from the few senders with loaded weights.
  function automatic logic [IDX_W-1:0] pick_sender();
    if ($urandom_range(0, 99) < 80) return IDX_W'($urandom_range(0, HOT_SENDERS - 1));
    return IDX_W'($urandom_range(0, 63));
  endfunction

  // Moderate Q8.8 weights keep the potential near the threshold; the rest are full range.
  function automatic q88_t pick_weight();
    if ($urandom_range(0, 99) < 85) return q88_t'($urandom_range(0, 512)) - 16'sd128;
    return q88_t'($urandom_range(0, 65535));
  endfunction

  // Offer one beat and hold it until it is taken. valid stays up between
  // back-to-back beats so it never gets two assignments in one step.
  task automatic push_item(func_t f, logic [IDX_W-1:0] src, q88_t w);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid        <= 1'b1;
    in_func         <= f;
    in_sender_index <= src;
    in_weight_value <= w;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    if (f == FUNC_TICK) begin
      if (tick_now + 1 < run_len_now) begin
        tick_now++;
        items_sent++;
      end
    end else if (tick_now < run_len_now) begin
      items_sent++;
    end
  endtask

  // Sender stops until every result owed has come back.
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
  endtask

  function automatic void set_regs(logic [7:0] refr, logic [7:0] res, logic [15:0] tau,
                                   q88_t thr, q88_t stp, logic mode, logic [15:0] run);
    regs_next[REG_REFRACTORY] = 16'(refr);
    regs_next[REG_RESISTANCE] = 16'(res);
    regs_next[REG_TAU_RECIP]  = tau;
    regs_next[REG_THRESHOLD]  = thr;
    regs_next[REG_SPIKE_STEP] = stp;
    regs_next[REG_INPUT_MODE] = 16'(mode);
    regs_next[REG_RUN_LENGTH] = run;
  endfunction

  // Registers change only with the block idle; all seven are written every time,
  // one per cycle, cfg_we held high across the burst.
  task automatic load_config();
    drain();
    for (int i = 0; i < REG_COUNT; i++) begin
      cfg_we    <= 1'b1;
      cfg_index <= cfg_idx_t'(i);
      cfg_wdata <= regs_next[cfg_idx_t'(i)];
      @(posedge clk);
    end
    cfg_we      <= 1'b0;
    run_len_now = regs_next[REG_RUN_LENGTH];
    phases_run++;
  endtask

  // Settings for a random phase. Phase 2 is input mode, 4 and 5 zero the gain
  // and the leak factor, 6 puts the run end a few ticks ahead, 7 ends the run
  // outright, and 8 onwards reopen it.
  task automatic roll_settings(int p);
    int          roll;
    logic [7:0]  refr;
    logic [7:0]  res;
    logic [15:0] tau;
    q88_t        thr;
    q88_t        stp;
    logic [15:0] run;
    roll = $urandom_range(0, 99);
    if (roll < 40) refr = 8'($urandom_range(0, 3));
    else if (roll < 80) refr = 8'($urandom_range(4, 40));
    else if (roll < 92) refr = 8'd0;
    else refr = 8'd255;
    roll = $urandom_range(0, 99);
    if (p == 4) res = 8'd0;
    else if (roll < 15) res = 8'd1;
    else if (roll < 30) res = 8'd255;
    else res = 8'($urandom_range(2, 64));
    roll = $urandom_range(0, 99);
    if (p == 5) tau = 16'd0;
    else if (roll < 10) tau = 16'hffff;
    else if (roll < 18) tau = 16'd1;
    else tau = 16'($urandom_range(8192, 65535));
    roll = $urandom_range(0, 99);
    if (roll < 10) thr = 16'sh7fff;
    else if (roll < 18) thr = 16'sh8000;
    else thr = q88_t'($urandom_range(0, 2304)) - 16'sd256;
    roll = $urandom_range(0, 99);
    if (roll < 10) stp = 16'sh7fff;
    else if (roll < 20) stp = 16'sh8000;
    else stp = q88_t'($urandom_range(0, 768)) - 16'sd256;
    if (p == 6) run = 16'(tick_now + 10);
    else if (p == 7) run = 16'd1;
    else run = 16'hffff;
    set_regs(refr, res, tau, thr, stp, (p == 2), run);
  endtask

  // One random phase: load weights for the busy senders, then mostly
  // spike bursts closed by a tick, mixed with stimuli, weight updates,
  // random noise beats and the odd full drain.
  task automatic run_phase(int p);
    int len;
    int n;
    int roll;
    int burst;
    bit held;
    held = 1'b0;
    roll_settings(p);
    load_config();
    gaps_on = (p % 4) != 3;
    len = (p == 6 || p == 7) ? SHORT_PHASE : PHASE_ITEMS;
    for (int s = 0; s < HOT_SENDERS; s++) push_item(FUNC_WRITE, IDX_W'(s), pick_weight());
    n = HOT_SENDERS;
    while (n < len) begin
      if ((p == 1 || p == 9) && n >= 40 && !held) begin
        holds_asked++;
        held = 1'b1;
      end
      roll = $urandom_range(0, 99);
      if (roll < 60) begin
        burst = $urandom_range(1, 5);
        repeat (burst) push_item(FUNC_SPIKE, pick_sender(), pick_weight());
        push_item(FUNC_TICK, pick_sender(), pick_weight());
        n += burst + 1;
      end else if (roll < 70) begin
        push_item(FUNC_TICK, pick_sender(), pick_weight());
        n++;
      end else if (roll < 78) begin
        push_item(FUNC_STIM, pick_sender(), pick_weight());
        n++;
      end else if (roll < 88) begin
        push_item(FUNC_WRITE, pick_sender(), pick_weight());
        n++;
      end else if (roll < 97) begin
        push_item(func_t'($urandom_range(0, 3)), IDX_W'($urandom_range(0, 63)),
                  q88_t'($urandom_range(0, 65535)));
        n++;
      end else begin
        drain();
      end
    end
  endtask

  initial begin
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Reset settings: extreme weights, current saturating both ways, a sender
    // never written, a forced firing and a tick inside the refractory window.
    push_item(FUNC_WRITE, 6'd0, 16'sh7fff);
    push_item(FUNC_WRITE, 6'd63, 16'sh8000);
    push_item(FUNC_WRITE, 6'd21, 16'sh5555);
    push_item(FUNC_WRITE, 6'd42, 16'shaaaa);
    push_item(FUNC_SPIKE, 6'd0, 16'sd0);
    push_item(FUNC_SPIKE, 6'd0, 16'sd0);
    push_item(FUNC_SPIKE, 6'd63, 16'sd0);
    push_item(FUNC_SPIKE, 6'd63, 16'sd0);
    push_item(FUNC_SPIKE, 6'd63, 16'sd0);
    push_item(FUNC_SPIKE, 6'd10, 16'sd0);
    push_item(FUNC_STIM, 6'd0, 16'sd0);
    push_item(FUNC_TICK, 6'd0, 16'sd0);

    // No refractory hold, full gain, lowest threshold, largest step:
    // potential saturates high on a tick, then low with a full negative current.
    set_regs(8'd0, 8'd255, 16'hffff, 16'sh8000, 16'sh7fff, 1'b0, 16'hffff);
    load_config();
    push_item(FUNC_SPIKE, 6'd0, 16'sd0);
    push_item(FUNC_TICK, 6'd0, 16'sd0);
    push_item(FUNC_STIM, 6'd0, 16'sd0);
    push_item(FUNC_SPIKE, 6'd63, 16'sd0);
    push_item(FUNC_SPIKE, 6'd63, 16'sd0);
    push_item(FUNC_TICK, 6'd0, 16'sd0);

    // Longest hold, smallest gain and leak, top threshold, most negative step.
    set_regs(8'd255, 8'd1, 16'd1, 16'sh7fff, 16'sh8000, 1'b0, 16'hffff);
    load_config();
    push_item(FUNC_SPIKE, 6'd42, 16'sd0);
    push_item(FUNC_TICK, 6'd0, 16'sd0);
    push_item(FUNC_STIM, 6'd0, 16'sd0);

    // Input mode: ticks only move time, current is kept.
    set_regs(8'd2, 8'd20, 16'd30000, 16'sd300, 16'sd64, 1'b1, 16'hffff);
    load_config();
    push_item(FUNC_TICK, 6'd0, 16'sd0);
    push_item(FUNC_SPIKE, 6'd21, 16'sd0);
    push_item(FUNC_TICK, 6'd0, 16'sd0);
    push_item(FUNC_STIM, 6'd0, 16'sd0);

    for (int p = 0; items_sent < ITEM_GOAL; p++) run_phase(p);

    drain();
    repeat (SETTLE_CYCLES) @(posedge clk);
    $display("covered %0d live beats over %0d register settings, with spike bursts,",
             items_sent, phases_run);
    $display("forced firings, input mode, zero gain and leak, run end and a long hold-off");
    if (mismatches == 0) $display("end of test: clean");
    else $display("end of test: mismatches");
    $finish;
  end

endmodule
